### hdl/tts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tts_pkg
// Shared types, constants and microcode for the template token scanner.
// ----------------------------------------------------------------------------
package tts_pkg;

  localparam int TOKEN_CAPACITY = 32;

  localparam logic [7:0]  CH_PCT   = 8'h25;
  localparam logic [7:0]  CH_COLON = 8'h3a;
  localparam logic [39:0] PFX_HTML = "html:";
  localparam logic [15:0] PFX_H    = "h:";
  localparam logic [23:0] PFX_JS   = "js:";
  localparam logic [15:0] PFX_J    = "j:";

  typedef enum logic [1:0] {
    KIND_TEXT = 2'd0,
    KIND_NAME = 2'd1,
    KIND_END  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ENC_PLAIN = 2'd0,
    ENC_HTML  = 2'd1,
    ENC_JS    = 2'd2
  } enc_t;

  // output byte source
  typedef enum logic [1:0] {
    BSEL_C,
    BSEL_PCT,
    BSEL_RDATA,
    BSEL_ZERO
  } bsel_t;

  typedef enum logic [2:0] {
    J_NEXT,
    J_WAIT_IN,
    J_DISPATCH,
    J_IDX_END,
    J_GOTO
  } jump_t;

  // classification of the latched input byte
  typedef enum logic [2:0] {
    CL_TEXT,
    CL_OPEN,
    CL_PCT,
    CL_CLOSE,
    CL_BAD,
    CL_STORE
  } class_t;

  typedef logic [3:0] upc_t;

  localparam upc_t U_FETCH    = 4'd0;
  localparam upc_t U_DISPATCH = 4'd1;
  localparam upc_t U_TEXT_C   = 4'd2;
  localparam upc_t U_OPEN     = 4'd3;
  localparam upc_t U_PCT      = 4'd4;
  localparam upc_t U_STORE    = 4'd5;
  localparam upc_t U_ERR0     = 4'd6;
  localparam upc_t U_ERR_RD   = 4'd7;
  localparam upc_t U_ERR_EM   = 4'd8;
  localparam upc_t U_ERR_C    = 4'd9;
  localparam upc_t U_NAME0    = 4'd10;
  localparam upc_t U_NAME_RD  = 4'd11;
  localparam upc_t U_NAME_EM  = 4'd12;
  localparam upc_t U_END      = 4'd13;

  typedef struct packed {
    logic  take;
    logic  emit;
    kind_t kind;
    bsel_t bsel;
    logic  use_enc;
    logic  last;
    logic  open;
    logic  store;
    logic  close;
    logic  idx_zero;
    logic  idx_skip;
    logic  idx_inc;
    logic  ram_rd;
    logic  done;
    jump_t jump;
    upc_t  target;
  } uword_t;

  typedef struct packed {
    logic   in_valid;
    logic   out_free;
    logic   idx_end;
    class_t cls;
  } status_t;

  function automatic uword_t ucode(upc_t pc);
    uword_t w;
    w = '0;
    w.kind = KIND_TEXT;
    w.bsel = BSEL_C;
    w.jump = J_GOTO;
    w.target = U_FETCH;
    case (pc)
      U_FETCH: begin
        w.take = 1'b1;
        w.jump = J_WAIT_IN;
      end
      U_DISPATCH: begin
        w.jump = J_DISPATCH;
      end
      U_TEXT_C: begin
        w.emit = 1'b1;
        w.last = 1'b1;
        w.done = 1'b1;
      end
      U_OPEN: begin
        w.open = 1'b1;
        w.done = 1'b1;
      end
      U_PCT: begin
        w.emit = 1'b1;
        w.bsel = BSEL_PCT;
        w.last = 1'b1;
        w.close = 1'b1;
        w.done = 1'b1;
      end
      U_STORE: begin
        w.store = 1'b1;
        w.done = 1'b1;
      end
      U_ERR0: begin
        w.emit = 1'b1;
        w.bsel = BSEL_PCT;
        w.idx_zero = 1'b1;
        w.jump = J_NEXT;
      end
      U_ERR_RD: begin
        w.ram_rd = 1'b1;
        w.jump = J_IDX_END;
        w.target = U_ERR_C;
      end
      U_ERR_EM: begin
        w.emit = 1'b1;
        w.bsel = BSEL_RDATA;
        w.idx_inc = 1'b1;
        w.target = U_ERR_RD;
      end
      U_ERR_C: begin
        w.emit = 1'b1;
        w.last = 1'b1;
        w.close = 1'b1;
        w.done = 1'b1;
      end
      U_NAME0: begin
        w.idx_skip = 1'b1;
        w.jump = J_NEXT;
      end
      U_NAME_RD: begin
        w.ram_rd = 1'b1;
        w.jump = J_IDX_END;
        w.target = U_END;
      end
      U_NAME_EM: begin
        w.emit = 1'b1;
        w.kind = KIND_NAME;
        w.bsel = BSEL_RDATA;
        w.use_enc = 1'b1;
        w.idx_inc = 1'b1;
        w.target = U_NAME_RD;
      end
      U_END: begin
        w.emit = 1'b1;
        w.kind = KIND_END;
        w.bsel = BSEL_ZERO;
        w.use_enc = 1'b1;
        w.last = 1'b1;
        w.close = 1'b1;
        w.done = 1'b1;
      end
      default: begin
        w.jump = J_GOTO;
        w.target = U_FETCH;
      end
    endcase
    return w;
  endfunction

endpackage

### hdl/tts_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tts_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hdl/tts_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tts_seq
// Microcode sequencer: step counter, control word lookup and jump logic.
// ----------------------------------------------------------------------------
module tts_seq (
  input  logic             clk,
  input  logic             rst,
  input  tts_pkg::status_t st,
  output tts_pkg::uword_t  ctrl,
  output logic             go
);

  tts_pkg::upc_t pc;
  tts_pkg::upc_t pc_next;
  tts_pkg::upc_t pc_inc;
  tts_pkg::upc_t dispatch;

  assign ctrl   = tts_pkg::ucode(pc);
  assign pc_inc = pc + tts_pkg::upc_t'(1);
  assign go     = !(ctrl.emit && !st.out_free) && !(ctrl.take && !st.in_valid);

  always_comb begin
    case (st.cls)
      tts_pkg::CL_TEXT:  dispatch = tts_pkg::U_TEXT_C;
      tts_pkg::CL_OPEN:  dispatch = tts_pkg::U_OPEN;
      tts_pkg::CL_PCT:   dispatch = tts_pkg::U_PCT;
      tts_pkg::CL_CLOSE: dispatch = tts_pkg::U_NAME0;
      tts_pkg::CL_BAD:   dispatch = tts_pkg::U_ERR0;
      tts_pkg::CL_STORE: dispatch = tts_pkg::U_STORE;
      default:           dispatch = tts_pkg::U_FETCH;
    endcase
  end

  always_comb begin
    pc_next = pc;
    if (go) begin
      case (ctrl.jump)
        tts_pkg::J_NEXT:     pc_next = pc_inc;
        tts_pkg::J_WAIT_IN:  pc_next = pc_inc;
        tts_pkg::J_DISPATCH: pc_next = dispatch;
        tts_pkg::J_IDX_END:  pc_next = st.idx_end ? ctrl.target : pc_inc;
        tts_pkg::J_GOTO:     pc_next = ctrl.target;
        default:             pc_next = tts_pkg::U_FETCH;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= tts_pkg::U_FETCH;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

### hdl/tts_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tts_dp
// Datapath: input latch, token store, prefix tracking, index walk and
// output register.
// ----------------------------------------------------------------------------
module tts_dp #(
  parameter int TOKEN_CAPACITY = tts_pkg::TOKEN_CAPACITY
) (
  input  logic             clk,
  input  logic             rst,
  input  tts_pkg::uword_t  ctrl,
  input  logic             go,
  output tts_pkg::status_t st,
  input  logic             s_tvalid,
  input  logic [7:0]       s_tdata,
  input  logic             s_tlast,
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [7:0]       m_tdata,
  output logic             m_tlast,
  output logic [3:0]       m_tuser
);

  localparam int LEN_W = $clog2(TOKEN_CAPACITY);

  logic [7:0]       c;
  logic             fin;
  logic             in_token;
  logic [LEN_W-1:0] len;
  logic [LEN_W-1:0] idx;
  tts_pkg::enc_t    enc;
  logic             f_html;
  logic             f_h;
  logic             f_js;
  logic             f_j;
  logic             hit_html;
  logic             hit_h;
  logic             hit_js;
  logic             hit_j;
  logic [LEN_W-1:0] skip;
  tts_pkg::enc_t    enc_sel;
  logic [7:0]       rdata;
  logic             name_ok;
  logic             full;
  tts_pkg::class_t  cls;
  logic [7:0]       byte_sel;
  tts_pkg::kind_t   out_kind;
  tts_pkg::enc_t    out_enc;

  assign name_ok = c inside {["a":"z"], ["A":"Z"], ["0":"9"], ".", "_", "-",
                             tts_pkg::CH_COLON};
  assign full = len >= LEN_W'(TOKEN_CAPACITY - 1);

  always_comb begin
    if (!in_token) begin
      cls = (c == tts_pkg::CH_PCT) ? tts_pkg::CL_OPEN : tts_pkg::CL_TEXT;
    end else if (c == tts_pkg::CH_PCT) begin
      cls = (len == '0) ? tts_pkg::CL_PCT : tts_pkg::CL_CLOSE;
    end else if (full || !name_ok) begin
      cls = tts_pkg::CL_BAD;
    end else begin
      cls = tts_pkg::CL_STORE;
    end
  end

  assign st.in_valid = s_tvalid;
  assign st.out_free = !m_tvalid || m_tready;
  assign st.idx_end  = idx == len;
  assign st.cls      = cls;

  // per-position match of the incoming byte against each prefix
  always_comb begin
    hit_html = 1'b1;
    hit_h    = 1'b1;
    hit_js   = 1'b1;
    hit_j    = 1'b1;
    case (len)
      LEN_W'(0): begin
        hit_html = c == tts_pkg::PFX_HTML[39:32];
        hit_h    = c == tts_pkg::PFX_H[15:8];
        hit_js   = c == tts_pkg::PFX_JS[23:16];
        hit_j    = c == tts_pkg::PFX_J[15:8];
      end
      LEN_W'(1): begin
        hit_html = c == tts_pkg::PFX_HTML[31:24];
        hit_h    = c == tts_pkg::PFX_H[7:0];
        hit_js   = c == tts_pkg::PFX_JS[15:8];
        hit_j    = c == tts_pkg::PFX_J[7:0];
      end
      LEN_W'(2): begin
        hit_html = c == tts_pkg::PFX_HTML[23:16];
        hit_js   = c == tts_pkg::PFX_JS[7:0];
      end
      LEN_W'(3): hit_html = c == tts_pkg::PFX_HTML[15:8];
      LEN_W'(4): hit_html = c == tts_pkg::PFX_HTML[7:0];
      default: begin
      end
    endcase
  end

  always_comb begin
    if (f_html && len >= LEN_W'(5)) begin
      skip = LEN_W'(5);
      enc_sel = tts_pkg::ENC_HTML;
    end else if (f_h && len >= LEN_W'(2)) begin
      skip = LEN_W'(2);
      enc_sel = tts_pkg::ENC_HTML;
    end else if (f_js && len >= LEN_W'(3)) begin
      skip = LEN_W'(3);
      enc_sel = tts_pkg::ENC_JS;
    end else if (f_j && len >= LEN_W'(2)) begin
      skip = LEN_W'(2);
      enc_sel = tts_pkg::ENC_JS;
    end else begin
      skip = '0;
      enc_sel = tts_pkg::ENC_PLAIN;
    end
  end

  tts_ram #(
    .WIDTH(8),
    .DEPTH(TOKEN_CAPACITY)
  ) u_store (
    .clk  (clk),
    .we   (go && ctrl.store),
    .waddr(len),
    .wdata(c),
    .re   (go && ctrl.ram_rd),
    .raddr(idx),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (go && ctrl.take) begin
      c   <= s_tdata;
      fin <= s_tlast;
    end
    if (go && ctrl.open) begin
      f_html <= 1'b1;
      f_h    <= 1'b1;
      f_js   <= 1'b1;
      f_j    <= 1'b1;
    end else if (go && ctrl.store) begin
      f_html <= f_html && hit_html;
      f_h    <= f_h && hit_h;
      f_js   <= f_js && hit_js;
      f_j    <= f_j && hit_j;
    end
    if (go && ctrl.idx_zero) begin
      idx <= '0;
    end else if (go && ctrl.idx_skip) begin
      idx <= skip;
      enc <= enc_sel;
    end else if (go && ctrl.idx_inc) begin
      idx <= idx + LEN_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_token <= 1'b0;
      len      <= '0;
    end else if (go) begin
      if (ctrl.done && fin) begin
        in_token <= 1'b0;
        len      <= '0;
      end else if (ctrl.open) begin
        in_token <= 1'b1;
        len      <= '0;
      end else if (ctrl.store) begin
        len <= len + LEN_W'(1);
      end else if (ctrl.close) begin
        in_token <= 1'b0;
        len      <= '0;
      end
    end
  end

  always_comb begin
    case (ctrl.bsel)
      tts_pkg::BSEL_C:     byte_sel = c;
      tts_pkg::BSEL_PCT:   byte_sel = tts_pkg::CH_PCT;
      tts_pkg::BSEL_RDATA: byte_sel = rdata;
      tts_pkg::BSEL_ZERO:  byte_sel = 8'h00;
      default:             byte_sel = 8'h00;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (go && ctrl.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go && ctrl.emit) begin
      m_tdata  <= byte_sel;
      m_tlast  <= ctrl.last;
      out_kind <= ctrl.kind;
      out_enc  <= ctrl.use_enc ? enc : tts_pkg::ENC_PLAIN;
    end
  end

  assign m_tuser = {out_enc, out_kind};

endmodule

### hdl/template_token_scanner_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// template_token_scanner_core
// Percent-delimited token scanner for template byte streams.
// ----------------------------------------------------------------------------
// Sequencing: an input byte is latched in the fetch step and classified in
// the dispatch step, and its first result, if any, is then registered onto
// m_tvalid. A new input byte is taken only once the last one is finished.
// A closing percent reads and emits, one by one, the M name bytes left after
// the prefix, a bad byte the N stored bytes, since the token store has one read
// port; any result can also wait on m_tready.
// Reset (rst, synchronous): scanner returns to plain text, output empties.
// ----------------------------------------------------------------------------
module template_token_scanner_core #(
  parameter int TOKEN_CAPACITY = tts_pkg::TOKEN_CAPACITY
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,  // [7:0] data_byte
  input  logic       s_tlast,  // final_req
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,  // [7:0] out_byte
  output logic       m_tlast,  // last
  output logic [3:0] m_tuser   // [1:0] kind, [3:2] encoding
);

  tts_pkg::uword_t  ctrl;
  tts_pkg::status_t st;
  logic             go;

  assign s_tready = ctrl.take;

  tts_seq u_seq (
    .clk (clk),
    .rst (rst),
    .st  (st),
    .ctrl(ctrl),
    .go  (go)
  );

  tts_dp #(
    .TOKEN_CAPACITY(TOKEN_CAPACITY)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (ctrl),
    .go      (go),
    .st      (st),
    .s_tvalid(s_tvalid),
    .s_tdata (s_tdata),
    .s_tlast (s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast),
    .m_tuser (m_tuser)
  );

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken on consecutive cycles");

  a_end_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1:0] == tts_pkg::KIND_END |-> m_tlast)
    else $error("end marker without last");

  a_text_plain: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1:0] == tts_pkg::KIND_TEXT |-> m_tuser[3:2] == tts_pkg::ENC_PLAIN)
    else $error("text result with encoding");

  a_no_take_busy: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready && !s_tready |=> m_tvalid)
    else $error("pending result lost");

endmodule
